@@ hdl/mbp_pkg.sv @@
// shared constants, command codes and queue entry type for the msb-first bit packer
`default_nettype none

package mbp_pkg;

   localparam int CODE_BITS       = 32;
   localparam int MAX_CODE_BITS   = 32;
   localparam int CNT_BITS        = 6;
   localparam int BYTE_INDEX_BITS = 16;
   localparam int TALLY_BITS      = 20;
   localparam int WRITTEN_BITS    = 19;
   localparam int MAX_BYTES       = 4;
   localparam int NBYTE_BITS      = 3;
   localparam int BUF_BITS        = 8 + CODE_BITS;
   localparam int Q_DEPTH         = 4;
   localparam int Q_PTR_BITS      = 2;

   localparam logic [BYTE_INDEX_BITS-1:0] CAP_RESET = '1;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_RSVD  = 2'd3
   } mbp_cmd_type;

   typedef struct packed {
      logic [8*MAX_BYTES-1:0]      bytes;
      logic [NBYTE_BITS-1:0]       nbytes;
      logic [BYTE_INDEX_BITS-1:0]  first_index;
      logic                        error;
      logic [WRITTEN_BITS-1:0]     written;
   } mbp_job_type;

endpackage

`default_nettype wire

@@ hdl/mbp_front.sv @@
// front end: holds the packing state and turns each command into a queue entry
`default_nettype none

module mbp_front
   import mbp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [1:0]                 command,
   input  wire logic [CODE_BITS-1:0]       code_value,
   input  wire logic [CNT_BITS-1:0]        bit_count,
   input  wire logic [BYTE_INDEX_BITS-1:0] capacity,
   input  wire logic                       q_full,
   output logic                            q_push,
   output mbp_job_type                     q_job
);

   logic [7:0]                 pend_ff, pend_in;
   logic [2:0]                 bit_pos_ff, bit_pos_in;
   logic [BYTE_INDEX_BITS-1:0] stream_pos_ff, stream_pos_in;
   logic [TALLY_BITS-1:0]      total_ff, total_in;

   logic [BYTE_INDEX_BITS:0] room;
   logic                     full;
   logic [CNT_BITS-1:0]      avail;
   logic                     cnt_ok;
   logic                     short_run;
   logic [CNT_BITS-1:0]      wr_bits;
   logic [CODE_BITS-1:0]     code_sh;
   logic [CODE_BITS:0]       mask_w;
   logic [CODE_BITS-1:0]     code_m;
   logic [BUF_BITS-1:0]      pack_buf;
   logic [CNT_BITS-1:0]      tot;
   logic [NBYTE_BITS-1:0]    nb;
   logic [7:0]               pend_wr;
   mbp_cmd_type              cmd;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;
   assign cmd        = mbp_cmd_type'(command);

   // write path
   always_comb begin
      room   = {1'b0, capacity} - {1'b0, stream_pos_ff};
      full   = stream_pos_ff >= capacity;
      if (room >= (BYTE_INDEX_BITS+1)'(MAX_BYTES + 1)) begin
         avail = CNT_BITS'(BUF_BITS);
      end else begin
         avail = {room[2:0], 3'b000} - {3'b000, bit_pos_ff};
      end
      cnt_ok    = (bit_count != '0) && (bit_count <= CNT_BITS'(MAX_CODE_BITS));
      short_run = bit_count > avail;
      if (!cnt_ok || full) begin
         wr_bits = '0;
      end else if (short_run) begin
         wr_bits = avail;
      end else begin
         wr_bits = bit_count;
      end
      code_sh  = code_value >> (bit_count - wr_bits);
      mask_w   = ((CODE_BITS+1)'(1) << wr_bits) - (CODE_BITS+1)'(1);
      code_m   = code_sh & mask_w[CODE_BITS-1:0];
      pack_buf = {pend_ff, {CODE_BITS{1'b0}}}
               | ({8'd0, code_m} << (CNT_BITS'(BUF_BITS) - {3'b000, bit_pos_ff} - wr_bits));
      tot      = {3'b000, bit_pos_ff} + wr_bits;
      nb       = tot[5:3];
      unique case (nb)
         3'd0:    pend_wr = pack_buf[39:32];
         3'd1:    pend_wr = pack_buf[31:24];
         3'd2:    pend_wr = pack_buf[23:16];
         3'd3:    pend_wr = pack_buf[15:8];
         3'd4:    pend_wr = pack_buf[7:0];
         default: pend_wr = '0;
      endcase
   end

   always_comb begin
      pend_in       = pend_ff;
      bit_pos_in    = bit_pos_ff;
      stream_pos_in = stream_pos_ff;
      total_in      = total_ff;
      q_job.bytes       = '0;
      q_job.nbytes      = '0;
      q_job.first_index = stream_pos_ff;
      q_job.error       = 1'b0;
      unique case (cmd)
         CMD_START: begin
            pend_in       = '0;
            bit_pos_in    = '0;
            stream_pos_in = '0;
            total_in      = '0;
         end
         CMD_WRITE: begin
            pend_in       = pend_wr;
            bit_pos_in    = tot[2:0];
            stream_pos_in = stream_pos_ff + BYTE_INDEX_BITS'(nb);
            total_in      = total_ff + TALLY_BITS'(wr_bits);
            q_job.bytes   = pack_buf[BUF_BITS-1:8];
            q_job.nbytes  = nb;
            q_job.error   = !cnt_ok || full || short_run;
         end
         CMD_FLUSH: begin
            if (bit_pos_ff != '0) begin
               pend_in       = '0;
               bit_pos_in    = '0;
               stream_pos_in = stream_pos_ff + BYTE_INDEX_BITS'(1);
               q_job.bytes   = {pend_ff, 24'd0};
               q_job.nbytes  = NBYTE_BITS'(1);
            end
         end
         CMD_RSVD: begin
            q_job.error = 1'b1;
         end
      endcase
      q_job.written = total_in[WRITTEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= '0;
         bit_pos_ff    <= '0;
         stream_pos_ff <= '0;
         total_ff      <= '0;
      end else if (q_push) begin
         pend_ff       <= pend_in;
         bit_pos_ff    <= bit_pos_in;
         stream_pos_ff <= stream_pos_in;
         total_ff      <= total_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/mbp_queue.sv @@
// short fifo of packed jobs between front end and result sequencer
`default_nettype none

module mbp_queue
   import mbp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  wire mbp_job_type push_job,
   input  wire logic  pop,
   output logic       full,
   output logic       not_empty,
   output mbp_job_type head
);

   mbp_job_type           entry_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_BITS:0]   count_ff;

   assign full      = count_ff == (Q_PTR_BITS+1)'(Q_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_BITS'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (Q_PTR_BITS+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (Q_PTR_BITS+1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/mbp_back.sv @@
// back end: splits each job into result beats behind an output register
`default_nettype none

module mbp_back
   import mbp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_valid,
   input  wire mbp_job_type                q_head,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic                            rsp_has_byte,
   output logic [7:0]                      rsp_data_byte,
   output logic [BYTE_INDEX_BITS-1:0]      rsp_byte_index,
   output logic                            rsp_error,
   output logic [WRITTEN_BITS-1:0]         rsp_written,
   output logic                            rsp_last
);

   logic [1:0]                 beat_ff, beat_in;
   logic                       valid_ff;
   logic                       has_ff;
   logic [7:0]                 byte_ff;
   logic [BYTE_INDEX_BITS-1:0] index_ff;
   logic                       err_ff;
   logic [WRITTEN_BITS-1:0]    written_ff;
   logic                       last_ff;

   logic                       load;
   logic                       is_last;
   logic                       has_in;
   logic [7:0]                 byte_in;

   assign load    = q_valid && (!valid_ff || rsp_tready);
   assign is_last = (q_head.nbytes == '0)
                 || ({1'b0, beat_ff} + NBYTE_BITS'(1) == q_head.nbytes);
   assign q_pop   = load && is_last;
   assign beat_in = is_last ? 2'd0 : beat_ff + 2'd1;
   assign has_in  = q_head.nbytes != '0;

   always_comb begin
      unique case (beat_ff)
         2'd0: byte_in = q_head.bytes[31:24];
         2'd1: byte_in = q_head.bytes[23:16];
         2'd2: byte_in = q_head.bytes[15:8];
         2'd3: byte_in = q_head.bytes[7:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            beat_ff  <= beat_in;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         has_ff     <= has_in;
         byte_ff    <= has_in ? byte_in : 8'd0;
         index_ff   <= has_in ? q_head.first_index + BYTE_INDEX_BITS'(beat_ff) : '0;
         err_ff     <= q_head.error && is_last;
         written_ff <= q_head.written;
         last_ff    <= is_last;
      end
   end

   assign rsp_tvalid     = valid_ff;
   assign rsp_has_byte   = has_ff;
   assign rsp_data_byte  = byte_ff;
   assign rsp_byte_index = index_ff;
   assign rsp_error      = err_ff;
   assign rsp_written    = written_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

@@ hdl/msb_first_bit_packer_top.sv @@
// after its transfer is accepted, the first result of an item passes the queue write,
// then the output register, when the queue and output register are free
// throughput: one item per cycle in while the queue has room; results leave one beat
// per cycle while rsp_tready is high, one to four per item on the one-byte channel
// a four-entry queue lets the input keep accepting while results drain
// reset (synchronous, active high) clears the packing state, queue and output valid;
// capacity returns to 65535
`default_nettype none

module msb_first_bit_packer_top
   import mbp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // code_value[31:0], bit_count[37:32], zero pad
   input  wire logic [1:0]  req_tuser,  // command[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // data_byte[7:0], byte_index[23:8], error[24],
                                        // bits_written[43:25], zero pad
   output logic [0:0]       rsp_tuser,  // has_byte[0]
   output logic             rsp_tlast
);

   logic [BYTE_INDEX_BITS-1:0] cap_ff;
   logic                       q_full, q_valid, q_push, q_pop;
   mbp_job_type                push_job, head_job;
   logic                       has_byte, error;
   logic [7:0]                 data_byte;
   logic [BYTE_INDEX_BITS-1:0] byte_index;
   logic [WRITTEN_BITS-1:0]    bits_written;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   mbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .command    (req_tuser),
      .code_value (req_tdata[31:0]),
      .bit_count  (req_tdata[37:32]),
      .capacity   (cap_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   mbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (push_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (head_job)
   );

   mbp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (head_job),
      .q_pop          (q_pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_has_byte   (has_byte),
      .rsp_data_byte  (data_byte),
      .rsp_byte_index (byte_index),
      .rsp_error      (error),
      .rsp_written    (bits_written),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, bits_written, error, byte_index, data_byte};
   assign rsp_tuser = has_byte;

`ifndef ASSERT_OFF
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("empty result not marked last");

   a_error_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[24] |-> rsp_tlast)
      else $error("error flag before final result");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[23:8] == $past(rsp_tdata[23:8]) + 16'd1))
      else $error("byte index did not advance within an item");
`endif

endmodule

`default_nettype wire
